// ----- rtl/positional_list_engine_macros.svh -----
// Assertion macros for the positional list engine checker
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// property must hold at every clock edge outside reset
`define PLE_ASSERT(label, clk_i, rstn_i, prop, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define PLE_NEVER(label, clk_i, rstn_i, cond, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rstn_i) !(cond)) else $error(msg);

`endif

// ----- rtl/plst_pkg.sv -----
// Shared types and constants for the positional list engine
`default_nettype none

package plst_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int CMD_W = 2;
	localparam int POS_W = 5;
	localparam int VAL_W = 32;
	localparam int ST_W  = 3;
	localparam int CNT_W = 5;

	localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RETRIEVE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_SEARCH   = 2'd3;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_BADPOS   = 3'd1;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

	// broadcast from the controller to every cell of the row
	typedef struct packed {
		logic             ins;
		logic             del;
		logic             rd;
		logic             srch;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] key;
	} plst_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/positional_list_engine.sv -----
// A result strobes on done once the start beat has passed the done_s1 and done_q registers.
// Throughput: one command per cycle; busy stays low, the cell row shifts in the accept cycle.
// Stage 1 registers each cell's select and compare; stage 2 reduces over the row.
// Reset clears the entry count and the done, search and hit flags; cell contents and result data are not cleared.
`default_nettype none

module positional_list_engine #(
	parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic        [plst_pkg::CMD_W-1:0]   cmd,
	input  wire logic        [plst_pkg::POS_W-1:0]   position,
	input  wire logic signed [plst_pkg::VAL_W-1:0]   value,
	output logic                                     done,
	output logic             [plst_pkg::ST_W-1:0]    status,
	output logic signed      [plst_pkg::VAL_W-1:0]   data,
	output logic                                     found,
	output logic             [plst_pkg::CNT_W-1:0]   count
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > plst_pkg::POS_W) ? CW + 1 : plst_pkg::POS_W + 1;

	logic                         accept;
	logic [CW-1:0]                cnt_q;
	logic [CW-1:0]                cnt_nxt;
	logic [CMPW-1:0]              cnt_x;
	logic [CMPW-1:0]              pos_x;
	logic                         full;
	logic                         empty;
	logic                         ins_ok;
	logic                         rd_ok;
	logic [plst_pkg::ST_W-1:0]    st_acc;
	plst_pkg::plst_ctl_t          ctl;

	logic [plst_pkg::VAL_W-1:0]   cell_val  [CAPACITY];
	logic [plst_pkg::VAL_W-1:0]   cell_data [CAPACITY];
	logic [CAPACITY-1:0]          cell_hit;

	logic                         done_s1;
	logic                         srch_s1;
	logic [plst_pkg::ST_W-1:0]    status_s1;
	logic [CW-1:0]                cnt_s1;

	logic                         any_hit;
	logic [plst_pkg::VAL_W-1:0]   rd_word;

	logic                         done_q;
	logic [plst_pkg::ST_W-1:0]    status_q;
	logic [plst_pkg::VAL_W-1:0]   data_q;
	logic                         found_q;
	logic [plst_pkg::CNT_W-1:0]   count_q;

	// the row absorbs a command every cycle
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign cnt_x  = CMPW'(cnt_q);
	assign pos_x  = CMPW'(position);
	assign full   = (cnt_q == CW'(CAPACITY));
	assign empty  = (cnt_q == '0);
	assign ins_ok = !full && (position != '0) && (pos_x <= cnt_x + CMPW'(1));
	assign rd_ok  = !empty && (position != '0) && (pos_x <= cnt_x);

	always_comb begin
		st_acc  = plst_pkg::ST_OK;
		cnt_nxt = cnt_q;
		unique case (cmd)
			plst_pkg::CMD_INSERT: begin
				if (full) begin
					st_acc = plst_pkg::ST_FULL;
				end else if (!ins_ok) begin
					st_acc = plst_pkg::ST_BADPOS;
				end else begin
					cnt_nxt = cnt_q + CW'(1);
				end
			end
			plst_pkg::CMD_DELETE, plst_pkg::CMD_RETRIEVE: begin
				if (empty) begin
					st_acc = plst_pkg::ST_EMPTY;
				end else if (!rd_ok) begin
					st_acc = plst_pkg::ST_BADPOS;
				end else if (cmd == plst_pkg::CMD_DELETE) begin
					cnt_nxt = cnt_q - CW'(1);
				end
			end
			plst_pkg::CMD_SEARCH: begin
				// hit or miss is settled in stage 2
				if (empty) begin
					st_acc = plst_pkg::ST_EMPTY;
				end
			end
			default: begin
				st_acc = plst_pkg::ST_OK;
			end
		endcase
	end

	always_comb begin
		ctl.ins  = accept && (cmd == plst_pkg::CMD_INSERT) && ins_ok;
		ctl.del  = accept && (cmd == plst_pkg::CMD_DELETE) && rd_ok;
		ctl.rd   = accept && ((cmd == plst_pkg::CMD_DELETE) ||
		                      (cmd == plst_pkg::CMD_RETRIEVE)) && rd_ok;
		ctl.srch = accept && (cmd == plst_pkg::CMD_SEARCH) && !empty;
		ctl.pos  = position;
		ctl.key  = value;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [plst_pkg::VAL_W-1:0] left_v;
		logic [plst_pkg::VAL_W-1:0] right_v;

		if (i == 0) begin : g_head
			assign left_v = ctl.key;
		end else begin : g_left
			assign left_v = cell_val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_v = cell_val[i];
		end else begin : g_right
			assign right_v = cell_val[i+1];
		end

		plst_cell #(
			.CAPACITY (CAPACITY),
			.IDX      (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.cnt       (cnt_q),
			.left_val  (left_v),
			.right_val (right_v),
			.val       (cell_val[i]),
			.data_s1   (cell_data[i]),
			.hit_s1    (cell_hit[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			done_s1 <= 1'b0;
			srch_s1 <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= cnt_nxt;
			end
			done_s1 <= accept;
			srch_s1 <= ctl.srch;
		end
	end

	always_ff @(posedge clk) begin
		status_s1 <= st_acc;
		cnt_s1    <= accept ? cnt_nxt : cnt_q;
	end

	// only the selected cell drives nonzero data
	always_comb begin
		any_hit = 1'b0;
		rd_word = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			any_hit = any_hit | cell_hit[i];
			rd_word = rd_word | cell_data[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= done_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (srch_s1) begin
			status_q <= any_hit ? plst_pkg::ST_OK : plst_pkg::ST_NOTFOUND;
		end else begin
			status_q <= status_s1;
		end
		data_q  <= rd_word;
		found_q <= srch_s1 && any_hit;
		count_q <= plst_pkg::CNT_W'(CMPW'(cnt_s1));
	end

	assign done   = done_q;
	assign status = status_q;
	assign data   = data_q;
	assign found  = found_q;
	assign count  = count_q;

endmodule

`default_nettype wire

// ----- rtl/plst_cell.sv -----
// One list cell: holds one entry, shifts with its neighbors, compares and selects
`default_nettype none

module plst_cell #(
	parameter int CAPACITY = plst_pkg::CAPACITY_DEF,
	parameter int IDX      = 0
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire plst_pkg::plst_ctl_t                   ctl,
	input  wire logic [$clog2(CAPACITY+1)-1:0]         cnt,
	input  wire logic [plst_pkg::VAL_W-1:0]            left_val,
	input  wire logic [plst_pkg::VAL_W-1:0]            right_val,
	output logic      [plst_pkg::VAL_W-1:0]            val,
	output logic      [plst_pkg::VAL_W-1:0]            data_s1,
	output logic                                       hit_s1
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > plst_pkg::POS_W) ? CW + 1 : plst_pkg::POS_W + 1;
	localparam logic [CMPW-1:0] SLOT = CMPW'(IDX + 1);

	logic [plst_pkg::VAL_W-1:0] val_q;
	logic [CMPW-1:0]            pos_x;
	logic [CMPW-1:0]            cnt_x;
	logic                       sel;
	logic                       live;

	assign pos_x = CMPW'(ctl.pos);
	assign cnt_x = CMPW'(cnt);
	assign sel   = (SLOT == pos_x);
	assign live  = (SLOT <= cnt_x);
	assign val   = val_q;

	// insert moves entries at and behind the position back; delete pulls them forward
	always_ff @(posedge clk) begin
		if (ctl.ins && (SLOT > pos_x)) begin
			val_q <= left_val;
		end else if (ctl.ins && sel) begin
			val_q <= ctl.key;
		end else if (ctl.del && (SLOT >= pos_x)) begin
			val_q <= right_val;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= (ctl.rd && sel) ? val_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
		end else begin
			hit_s1 <= ctl.srch && live && (val_q == ctl.key);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/plst_checker.sv -----
// Port-level checker for the positional list engine, bound to the top level
`default_nettype none
`include "positional_list_engine_macros.svh"

module plst_checker #(
	parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              start,
	input wire logic                              busy,
	input wire logic                              done,
	input wire logic [plst_pkg::ST_W-1:0]         status,
	input wire logic [plst_pkg::VAL_W-1:0]        data,
	input wire logic                              found,
	input wire logic [plst_pkg::CNT_W-1:0]        count
);

	logic [plst_pkg::CNT_W:0] count_x;
	logic                     count_hi;

	assign count_x  = (plst_pkg::CNT_W + 1)'(count);
	assign count_hi = (CAPACITY < 32) && (32'(count_x) > 32'(CAPACITY));

	`PLE_ASSERT(a_beat_gives_result, clk, arst_n, (start && !busy) |-> ##2 done, "accepted beat without result")
	`PLE_ASSERT(a_no_phantom_result, clk, arst_n, done |-> $past(start && !busy, 2), "result without accepted beat")
	`PLE_NEVER(a_found_means_ok, clk, arst_n, done && found && (status != plst_pkg::ST_OK), "found with failing status")
	`PLE_NEVER(a_fail_has_no_data, clk, arst_n, done && (status != plst_pkg::ST_OK) && (data != '0), "data on failing status")
	`PLE_NEVER(a_count_in_range, clk, arst_n, done && count_hi, "count above capacity")

endmodule

bind positional_list_engine plst_checker #(
	.CAPACITY (CAPACITY)
) u_plst_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.status (status),
	.data   (data),
	.found  (found),
	.count  (count)
);

`default_nettype wire

// ----- tb/list_shadow_check.sv -----
// Checker for the positional list engine: shadow list, expected results, field compare
`timescale 1ns / 1ps

module list_shadow_check
	import plst_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic                    busy,
	input  wire logic [CMD_W-1:0]        cmd,
	input  wire logic [POS_W-1:0]        position,
	input  wire logic signed [VAL_W-1:0] value,
	input  wire logic                    done,
	input  wire logic [ST_W-1:0]         status,
	input  wire logic signed [VAL_W-1:0] data,
	input  wire logic                    found,
	input  wire logic [CNT_W-1:0]        count,
	output int                           errors,
	output int                           outstanding,
	output int                           checked,
	output int                           list_len
);

	typedef struct packed {
		logic [ST_W-1:0]         status;
		logic signed [VAL_W-1:0] data;
		logic                    found;
		logic [CNT_W-1:0]        count;
	} list_result_t;

	logic signed [VAL_W-1:0] shadow_words [CAPACITY];
	int                      fill;
	list_result_t            awaiting_results [$];

	assign list_len = fill;

	task automatic apply_list_cmd(
		input  logic [CMD_W-1:0]        op,
		input  logic [POS_W-1:0]        pos,
		input  logic signed [VAL_W-1:0] key,
		output list_result_t            res
	);
		int i;
		int p;
		p = int'(pos);
		res = '0;
		case (op)
			CMD_INSERT: begin
				// full wins over a bad position
				if (fill >= CAPACITY)
					res.status = ST_FULL;
				else if (p == 0 || p > fill + 1)
					res.status = ST_BADPOS;
				else begin
					for (i = fill; i >= p; i--)
						shadow_words[i] = shadow_words[i-1];
					shadow_words[p-1] = key;
					fill++;
					res.status = ST_OK;
				end
			end
			CMD_DELETE, CMD_RETRIEVE: begin
				if (fill == 0)
					res.status = ST_EMPTY;
				else if (p == 0 || p > fill)
					res.status = ST_BADPOS;
				else begin
					res.status = ST_OK;
					res.data = shadow_words[p-1];
					if (op == CMD_DELETE) begin
						for (i = p; i < fill; i++)
							shadow_words[i-1] = shadow_words[i];
						fill--;
					end
				end
			end
			CMD_SEARCH: begin
				if (fill == 0)
					res.status = ST_EMPTY;
				else begin
					res.status = ST_NOTFOUND;
					for (i = 0; i < fill; i++) begin
						if (shadow_words[i] == key) begin
							res.status = ST_OK;
							res.found = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		res.count = fill[CNT_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		list_result_t fresh;
		if (!arst_n) begin
			awaiting_results.delete();
			fill = 0;
			errors = 0;
			checked = 0;
			outstanding = 0;
		end else begin
			// older beat first, so a stray strobe is never matched to this cycle's item
			if (done) begin
				if (awaiting_results.size() == 0) begin
					$error("result strobe with no command outstanding");
					errors++;
				end else begin
					want = awaiting_results.pop_front();
					checked++;
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						errors++;
					end
					if (data !== want.data) begin
						$error("data: expected %0d, actual %0d", want.data, data);
						errors++;
					end
					if (found !== want.found) begin
						$error("found: expected %0d, actual %0d", want.found, found);
						errors++;
					end
					if (count !== want.count) begin
						$error("count: expected %0d, actual %0d", want.count, count);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				apply_list_cmd(cmd, position, value, fresh);
				awaiting_results.push_back(fresh);
			end
			outstanding = awaiting_results.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the positional list engine: clock, reset, command stimulus, verdict
`timescale 1ns / 1ps

module tb;
	import plst_pkg::*;

	localparam int RANDOM_CMDS = 450;
	localparam int QUIET_TAIL  = 60;
	localparam int STALL_LIMIT = 500;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [CMD_W-1:0]        cmd;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] value;
	logic                    done;
	logic [ST_W-1:0]         status;
	logic signed [VAL_W-1:0] data;
	logic                    found;
	logic [CNT_W-1:0]        count;

	int errors;
	int outstanding;
	int checked;
	int list_len;
	int sent;
	int full_tries;
	int stall_cycles;
	logic signed [VAL_W-1:0] recent_words [$];

	positional_list_engine u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.position (position),
		.value    (value),
		.done     (done),
		.status   (status),
		.data     (data),
		.found    (found),
		.count    (count)
	);

	list_shadow_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.position    (position),
		.value       (value),
		.done        (done),
		.status      (status),
		.data        (data),
		.found       (found),
		.count       (count),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked),
		.list_len    (list_len)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog: cycles with neither a command beat nor a result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// one command beat; entered and left at a falling edge
	task automatic send_cmd(
		input logic [CMD_W-1:0]        op,
		input int                      pos,
		input logic signed [VAL_W-1:0] key
	);
		start <= 1'b1;
		cmd <= op;
		position <= pos[POS_W-1:0];
		value <= key;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		sent++;
		if (op == CMD_INSERT) begin
			recent_words.push_back(key);
			if (recent_words.size() > 8)
				void'(recent_words.pop_front());
		end
	endtask

	task automatic hold_off(input int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain;
		start <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	function automatic logic signed [VAL_W-1:0] pick_word(input bit reuse);
		if (reuse && recent_words.size() > 0)
			return recent_words[$urandom_range(0, recent_words.size() - 1)];
		case ($urandom_range(0, 9))
			0:       return 32'sh7fffffff;
			1:       return 32'sh80000000;
			2:       return 32'sh0;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int  n;
		int  roll;
		int  pos;
		bit  grow;
		logic [CMD_W-1:0] op;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_INSERT;
		position = '0;
		value = '0;
		sent = 0;
		full_tries = 0;
		stall_cycles = 0;
		grow = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty list cases
		send_cmd(CMD_SEARCH, 1, 32'sd5);
		send_cmd(CMD_DELETE, 1, 32'sd0);
		send_cmd(CMD_RETRIEVE, 0, 32'sd0);
		send_cmd(CMD_INSERT, 0, 32'sd9);
		send_cmd(CMD_INSERT, 2, 32'sd9);
		// build a short list with extreme words
		send_cmd(CMD_INSERT, 1, 32'sh7fffffff);
		send_cmd(CMD_INSERT, 2, 32'sh80000000);
		send_cmd(CMD_INSERT, 1, 32'sd0);
		send_cmd(CMD_INSERT, 4, -32'sd1);
		hold_off(3);
		send_cmd(CMD_RETRIEVE, 0, 32'sd0);
		send_cmd(CMD_RETRIEVE, 5, 32'sd0);
		for (n = 1; n <= 4; n++)
			send_cmd(CMD_RETRIEVE, n, 32'sd0);
		send_cmd(CMD_SEARCH, 31, 32'sh80000000);
		send_cmd(CMD_SEARCH, 0, 32'sd12345);
		send_cmd(CMD_DELETE, 5, 32'sd0);
		send_cmd(CMD_DELETE, 4, 32'sd0);
		send_cmd(CMD_DELETE, 0, 32'sd0);
		send_cmd(CMD_DELETE, 1, 32'sd0);
		send_cmd(CMD_RETRIEVE, 17, 32'sd0);

		// sender waits for every outstanding result before the random part
		drain();

		for (n = 0; n < RANDOM_CMDS; n++) begin
			if (n % 40 == 0)
				grow = !grow;
			if (n % 150 == 149)
				drain();
			roll = $urandom_range(0, 99);
			if ($urandom_range(0, 99) < 15) begin
				// noise: any command at any position from 0 to 17
				op = CMD_W'($urandom_range(0, 3));
				pos = $urandom_range(0, 17);
			end else begin
				if (roll < (grow ? 55 : 15))
					op = CMD_INSERT;
				else if (roll < 70)
					op = grow ? CMD_DELETE : CMD_INSERT;
				else if (roll < 85)
					op = CMD_RETRIEVE;
				else
					op = CMD_SEARCH;
				if (!grow && op == CMD_INSERT && roll >= 15)
					op = CMD_DELETE;
				if (op == CMD_INSERT)
					pos = $urandom_range(1, list_len + 1);
				else if (list_len == 0)
					pos = $urandom_range(1, 17);
				else
					pos = $urandom_range(1, list_len);
			end
			if (op == CMD_INSERT && list_len >= CAPACITY_DEF)
				full_tries++;
			send_cmd(op, pos, pick_word(op == CMD_SEARCH ? ($urandom_range(0, 9) < 6)
				: ($urandom_range(0, 9) < 3)));
			if (n < RANDOM_CMDS - QUIET_TAIL && $urandom_range(0, 99) < 20)
				hold_off($urandom_range(1, 18));
		end

		drain();
		repeat (8) @(posedge clk);
		$display("sent %0d commands, checked %0d results", sent, checked);
		$display("inserts attempted on a full list: %0d", full_tries);
		if (errors == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
